// ===== design/butterworth_lowpass_iir_macros.svh =====
// Assertion macros shared by the filter RTL.
`ifndef BUTTERWORTH_LOWPASS_IIR_MACROS_SVH
`define BUTTERWORTH_LOWPASS_IIR_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define BWL_ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define BWL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/bwl_pkg.sv =====
// Shared types, widths, constants and helper functions of the low-pass filter.
package bwl_pkg;

  // Filter order and derived sequencing widths.
  localparam int ORDER     = 4;
  localparam int NUM_COEF  = 4;
  localparam int NUM_STEPS = 2 + 2 * ORDER;
  localparam int STEP_W    = $clog2(NUM_STEPS);
  localparam int IDX_W     = (ORDER > 1) ? $clog2(ORDER) : 1;
  localparam int PIPE_LAT  = 2;

  // Field and datapath widths.
  localparam int SAMPLE_W   = 24;
  localparam int GAIN_W     = 40;
  localparam int GAIN_SPLIT = 20;
  localparam int COEF_W     = 32;
  localparam int HIST_IN_W  = 40;
  localparam int HIST_OUT_W = 48;
  localparam int ACC_W      = 58;
  localparam int OPA_W      = 33;
  localparam int OPB_W      = 25;
  localparam int PROD_W     = OPA_W + OPB_W;
  localparam int LO_W       = 48;
  localparam int GSUM_W     = 64;
  localparam int XS_SHIFT   = 24;
  localparam int FB_SPLIT   = 24;
  localparam int FB_SHIFT   = 4;
  localparam int OUT_SHIFT  = 16;
  localparam int BINOM_W    = 3;

  localparam logic [LO_W-1:0] ROUND_HALF = LO_W'(1) << (XS_SHIFT - 1);

  // Configuration port.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 40;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_INPUT_GAIN     = 3'd0,
    REG_FEEDBACK_ONE   = 3'd1,
    REG_FEEDBACK_TWO   = 3'd2,
    REG_FEEDBACK_THREE = 3'd3,
    REG_FEEDBACK_FOUR  = 3'd4
  } reg_idx_t;

  // Binomial weights, row n holds n choose k.
  localparam logic [BINOM_W-1:0] BINOM_TAB [0:4][0:4] = '{
    '{3'd1, 3'd0, 3'd0, 3'd0, 3'd0},
    '{3'd1, 3'd1, 3'd0, 3'd0, 3'd0},
    '{3'd1, 3'd2, 3'd1, 3'd0, 3'd0},
    '{3'd1, 3'd3, 3'd3, 3'd1, 3'd0},
    '{3'd1, 3'd4, 3'd6, 3'd4, 3'd1}
  };

  // Micro-operations of the shared multiplier.
  typedef enum logic [1:0] {
    OP_GAIN_LO = 2'd0,
    OP_GAIN_HI = 2'd1,
    OP_FB_LO   = 2'd2,
    OP_FB_HI   = 2'd3
  } op_t;

  typedef struct packed {
    logic             valid;
    op_t              op;
    logic [IDX_W-1:0] idx;
  } tag_t;

  typedef struct packed {
    logic idle;
    logic commit;
  } seq_ctl_t;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_RUN   = 4'b0010,
    ST_DRAIN = 4'b0100,
    ST_FIN   = 4'b1000
  } state_t;

  // Weight of the input history entry delayed idx+1 samples.
  function automatic logic [BINOM_W-1:0] binom_weight(input logic [IDX_W-1:0] idx);
    return BINOM_TAB[ORDER][int'(idx) + 1];
  endfunction

  // Saturate the accumulator to the stored history width.
  function automatic logic signed [HIST_OUT_W-1:0] sat_hist(
    input logic signed [ACC_W-1:0] v
  );
    logic [ACC_W-HIST_OUT_W:0] top;
    top = v[ACC_W-1:HIST_OUT_W-1];
    if ((&top) || !(|top)) begin
      return v[HIST_OUT_W-1:0];
    end else if (v[ACC_W-1]) begin
      return {1'b1, {(HIST_OUT_W-1){1'b0}}};
    end else begin
      return {1'b0, {(HIST_OUT_W-1){1'b1}}};
    end
  endfunction

  // Saturate the shifted history value to the sample width.
  function automatic logic signed [SAMPLE_W-1:0] sat_out(
    input logic signed [HIST_OUT_W-OUT_SHIFT-1:0] v
  );
    logic [HIST_OUT_W-OUT_SHIFT-SAMPLE_W:0] top;
    top = v[HIST_OUT_W-OUT_SHIFT-1:SAMPLE_W-1];
    if ((&top) || !(|top)) begin
      return v[SAMPLE_W-1:0];
    end else if (v[HIST_OUT_W-OUT_SHIFT-1]) begin
      return {1'b1, {(SAMPLE_W-1){1'b0}}};
    end else begin
      return {1'b0, {(SAMPLE_W-1){1'b1}}};
    end
  endfunction

endpackage

// ===== design/bwl_in_if.sv =====
// Input sample channel.
interface bwl_in_if import bwl_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample_in;

  modport source (output valid, output sample_in, input ready);
  modport sink (input valid, input sample_in, output ready);
endinterface

// ===== design/bwl_out_if.sv =====
// Filtered sample channel.
interface bwl_out_if import bwl_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample_out;

  modport source (output valid, output sample_out, input ready);
  modport sink (input valid, input sample_out, output ready);
endinterface

// ===== design/bwl_cfg_if.sv =====
// Configuration write channel.
interface bwl_cfg_if import bwl_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ===== design/bwl_mul.sv =====
// Shared registered signed multiplier with its operation tag.
module bwl_mul import bwl_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic signed [OPA_W-1:0]  op_a,
  input  logic signed [OPB_W-1:0]  op_b,
  input  tag_t                     tag_in,
  output logic signed [PROD_W-1:0] prod,
  output tag_t                     tag_out
);

  logic signed [PROD_W-1:0] prod_r;
  tag_t                     tag_r;

  always_ff @(posedge clk) begin
    prod_r <= op_a * op_b;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_r <= '0;
    end else begin
      tag_r <= tag_in;
    end
  end

  assign prod    = prod_r;
  assign tag_out = tag_r;

endmodule

// ===== design/bwl_seq.sv =====
// Sequencer that steps the shared multiplier through one sample.
module bwl_seq import bwl_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  input  logic     out_free,
  output tag_t     issue,
  output seq_ctl_t ctl
);

  localparam logic [STEP_W-1:0] LAST_STEP  = STEP_W'(NUM_STEPS - 1);
  localparam logic [STEP_W-1:0] DRAIN_LAST = STEP_W'(PIPE_LAT - 1);

  state_t            st_r, st_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [STEP_W-1:0] step_m2;

  assign step_m2 = step_r - STEP_W'(2);

  always_comb begin
    st_nxt   = st_r;
    step_nxt = step_r;
    issue    = '0;
    ctl      = '0;
    unique case (st_r)
      ST_IDLE: begin
        ctl.idle = 1'b1;
        if (start) begin
          st_nxt   = ST_RUN;
          step_nxt = '0;
        end
      end
      ST_RUN: begin
        issue.valid = 1'b1;
        issue.idx   = step_m2[IDX_W:1];
        if (step_r == STEP_W'(0)) begin
          issue.op = OP_GAIN_LO;
        end else if (step_r == STEP_W'(1)) begin
          issue.op = OP_GAIN_HI;
        end else if (!step_r[0]) begin
          issue.op = OP_FB_LO;
        end else begin
          issue.op = OP_FB_HI;
        end
        if (step_r == LAST_STEP) begin
          st_nxt   = ST_DRAIN;
          step_nxt = '0;
        end else begin
          step_nxt = step_r + STEP_W'(1);
        end
      end
      ST_DRAIN: begin
        if (step_r == DRAIN_LAST) begin
          st_nxt = ST_FIN;
        end else begin
          step_nxt = step_r + STEP_W'(1);
        end
      end
      ST_FIN: begin
        if (out_free) begin
          ctl.commit = 1'b1;
          st_nxt     = ST_IDLE;
        end
      end
      default: begin
        st_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= ST_IDLE;
      step_r <= '0;
    end else begin
      st_r   <= st_nxt;
      step_r <= step_nxt;
    end
  end

endmodule

// ===== design/bwl_dp.sv =====
// Operand selection, term formation, accumulator and history of the filter.
module bwl_dp import bwl_pkg::*; (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic signed [SAMPLE_W-1:0] sample,
  input  logic        [GAIN_W-1:0]   gain,
  input  logic signed [COEF_W-1:0]   fb_coef [NUM_COEF],
  input  tag_t                       issue,
  input  logic                       commit,
  input  logic signed [PROD_W-1:0]   prod,
  input  tag_t                       prod_tag,
  output logic signed [OPA_W-1:0]    op_a,
  output logic signed [OPB_W-1:0]    op_b,
  output logic signed [SAMPLE_W-1:0] y
);

  logic signed [SAMPLE_W-1:0]   x_r;
  logic signed [HIST_IN_W-1:0]  ih_r [ORDER];
  logic signed [HIST_OUT_W-1:0] oh_r [ORDER];
  logic signed [LO_W-1:0]       lo_r;
  logic signed [HIST_IN_W-1:0]  xs_r;
  logic signed [ACC_W-1:0]      term_r;
  logic                         term_vld_r;
  logic                         term_sub_r;
  logic signed [ACC_W-1:0]      acc_r;

  logic signed [HIST_OUT_W-1:0] oh_sel;
  logic signed [GSUM_W-1:0]     gsum;
  logic signed [PROD_W-1:0]     prod_sh;
  logic signed [PROD_W:0]       fsum;
  logic signed [PROD_W:0]       fsum_sh;
  logic signed [HIST_IN_W+BINOM_W:0] bprod;
  logic signed [HIST_OUT_W-1:0] acc_sat;

  // Pick multiplier operands for the issued step.
  assign oh_sel = oh_r[issue.idx];

  always_comb begin
    op_a = OPA_W'(x_r);
    op_b = '0;
    unique case (issue.op)
      OP_GAIN_LO: begin
        op_b = {{(OPB_W-GAIN_SPLIT){1'b0}}, gain[GAIN_SPLIT-1:0]};
      end
      OP_GAIN_HI: begin
        op_b = {{(OPB_W-GAIN_W+GAIN_SPLIT){1'b0}}, gain[GAIN_W-1:GAIN_SPLIT]};
      end
      OP_FB_LO: begin
        op_a = OPA_W'(fb_coef[issue.idx]);
        op_b = {1'b0, oh_sel[FB_SPLIT-1:0]};
      end
      OP_FB_HI: begin
        op_a = OPA_W'(fb_coef[issue.idx]);
        op_b = OPB_W'($signed(oh_sel[HIST_OUT_W-1:FB_SPLIT]));
      end
      default: begin
        op_b = '0;
      end
    endcase
  end

  // Combine product halves into terms.
  assign gsum    = {prod[GSUM_W-GAIN_SPLIT-1:0], {GAIN_SPLIT{1'b0}}} + GSUM_W'(lo_r);
  assign prod_sh = prod >>> FB_SPLIT;
  assign fsum    = (PROD_W+1)'(prod) + (PROD_W+1)'(lo_r);
  assign fsum_sh = fsum >>> FB_SHIFT;
  assign bprod   = ih_r[prod_tag.idx] * $signed({1'b0, binom_weight(prod_tag.idx)});

  always_ff @(posedge clk) begin
    if (start) begin
      x_r <= sample;
    end
    if (prod_tag.valid) begin
      unique case (prod_tag.op)
        OP_GAIN_LO: begin
          lo_r <= prod[LO_W-1:0] + ROUND_HALF;
        end
        OP_GAIN_HI: begin
          xs_r   <= gsum[GSUM_W-1:XS_SHIFT];
          term_r <= ACC_W'($signed(gsum[GSUM_W-1:XS_SHIFT]));
        end
        OP_FB_LO: begin
          lo_r   <= prod_sh[LO_W-1:0];
          term_r <= ACC_W'(bprod);
        end
        OP_FB_HI: begin
          term_r <= fsum_sh[ACC_W-1:0];
        end
        default: begin
          lo_r <= lo_r;
        end
      endcase
    end
    if (start) begin
      acc_r <= '0;
    end else if (term_vld_r) begin
      acc_r <= term_sub_r ? (acc_r - term_r) : (acc_r + term_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      term_vld_r <= 1'b0;
      term_sub_r <= 1'b0;
    end else begin
      term_vld_r <= prod_tag.valid && (prod_tag.op != OP_GAIN_LO);
      term_sub_r <= (prod_tag.op == OP_FB_HI);
    end
  end

  // Shift the histories once the sum is complete.
  assign acc_sat = sat_hist(acc_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < ORDER; k++) begin
        ih_r[k] <= '0;
        oh_r[k] <= '0;
      end
    end else if (commit) begin
      ih_r[0] <= xs_r;
      oh_r[0] <= acc_sat;
      for (int k = 1; k < ORDER; k++) begin
        ih_r[k] <= ih_r[k-1];
        oh_r[k] <= oh_r[k-1];
      end
    end
  end

  assign y = sat_out(acc_sat[HIST_OUT_W-1:OUT_SHIFT]);

endmodule

// ===== design/butterworth_lowpass_iir.sv =====
// Top level of the fourth-order Butterworth low-pass filter, direct form I.
//
// Takes one signed 24-bit sample per request and returns one filtered signed
// 24-bit sample per request, in order. Each sample is scaled by input_gain
// (unsigned Q0.40, rounded half up to Q24.16), combined with the past scaled
// inputs through binomial weights, and the past sums weighted by the four
// Q4.28 feedback registers are subtracted (each product floored). The exact
// sum is saturated to 48 bits, stored as the newest output history entry,
// and shifted right by 16 with saturation to 24 bits for the result. One
// 33x25 signed multiplier is shared by the gain and feedback products:
// two for the gain and two per feedback tap, with the binomial terms added
// in the free slots. A sample holds the block from acceptance until the
// input side is ready again: the sequencer issues the multiplier steps,
// drains the multiply and accumulate stages, commits once the output
// register is free, and returns to idle to take the next request. The
// result sits in an output register, so a new request is taken while it
// waits; the commit of the next one stalls until that register has been
// read. Configuration writes are always ready; indexes 0..4 select
// input_gain and feedback_one..feedback_four, other indexes are dropped.
// Write them only while the block is idle. Reset (rst_n low, synchronous)
// clears all histories, the configuration registers and the control state.
`include "butterworth_lowpass_iir_macros.svh"

module butterworth_lowpass_iir import bwl_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  bwl_in_if.sink    in_chan,
  bwl_out_if.source out_chan,
  bwl_cfg_if.sink   cfg_chan
);

  // Configuration registers.
  logic        [GAIN_W-1:0] gain_r;
  logic signed [COEF_W-1:0] fb_coef_r [NUM_COEF];

  // Output register.
  logic                       out_valid_r;
  logic signed [SAMPLE_W-1:0] out_sample_r;

  // Sequencer and datapath links.
  seq_ctl_t                   ctl;
  tag_t                       issue;
  tag_t                       prod_tag;
  logic signed [OPA_W-1:0]    op_a;
  logic signed [OPB_W-1:0]    op_b;
  logic signed [PROD_W-1:0]   prod;
  logic signed [SAMPLE_W-1:0] dp_y;
  logic                       start;
  logic                       out_free;

  // Take a request only when the sequencer has nothing in flight.
  assign in_chan.ready = ctl.idle;
  assign start         = in_chan.valid && ctl.idle;

  // The result slot is free when empty or being drained this cycle.
  assign out_free = !out_valid_r || out_chan.ready;

  // Configuration writes are registered; unknown indexes are dropped.
  assign cfg_chan.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r <= '0;
      for (int k = 0; k < NUM_COEF; k++) begin
        fb_coef_r[k] <= '0;
      end
    end else if (cfg_chan.valid) begin
      unique case (cfg_chan.index)
        REG_INPUT_GAIN:     gain_r       <= cfg_chan.data[GAIN_W-1:0];
        REG_FEEDBACK_ONE:   fb_coef_r[0] <= cfg_chan.data[COEF_W-1:0];
        REG_FEEDBACK_TWO:   fb_coef_r[1] <= cfg_chan.data[COEF_W-1:0];
        REG_FEEDBACK_THREE: fb_coef_r[2] <= cfg_chan.data[COEF_W-1:0];
        REG_FEEDBACK_FOUR:  fb_coef_r[3] <= cfg_chan.data[COEF_W-1:0];
        default: begin
          gain_r <= gain_r;
        end
      endcase
    end
  end

  // Step the shared multiplier through one sample.
  bwl_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .out_free (out_free),
    .issue    (issue),
    .ctl      (ctl)
  );

  // Shared multiplier: product and tag come back in the next cycle.
  bwl_mul u_mul (
    .clk     (clk),
    .rst_n   (rst_n),
    .op_a    (op_a),
    .op_b    (op_b),
    .tag_in  (issue),
    .prod    (prod),
    .tag_out (prod_tag)
  );

  // Operand muxing, term forming, accumulation and history.
  bwl_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .sample   (in_chan.sample_in),
    .gain     (gain_r),
    .fb_coef  (fb_coef_r),
    .issue    (issue),
    .commit   (ctl.commit),
    .prod     (prod),
    .prod_tag (prod_tag),
    .op_a     (op_a),
    .op_b     (op_b),
    .y        (dp_y)
  );

  // Hold the result until the sink takes it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctl.commit) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.commit) begin
      out_sample_r <= dp_y;
    end
  end

  assign out_chan.valid      = out_valid_r;
  assign out_chan.sample_out = out_sample_r;

  `BWL_ASSERT_NEXT(a_accept_busy, clk, rst_n, in_chan.valid && in_chan.ready, !in_chan.ready, "input ready stayed high after a request was taken")
  `BWL_ASSERT_IMPLIES(a_issue_busy, clk, rst_n, issue.valid, !in_chan.ready, "multiplier step issued while input was ready")
  `BWL_ASSERT_IMPLIES(a_commit_free, clk, rst_n, ctl.commit, out_free, "commit while the output register still held a result")
  `BWL_ASSERT_NEXT(a_commit_loads, clk, rst_n, ctl.commit, out_valid_r && (out_sample_r == $past(dp_y)), "committed result not presented")

endmodule
